// ===== hw/rtl/tpcvt_pkg.sv =====
package tpcvt_pkg;

    // Table geometry.
    localparam int NUM_SLOTS        = 16;
    localparam int MAX_PARTICIPANTS = 8;
    localparam int SLOT_W           = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NEXT_W           = $clog2(NUM_SLOTS + 1);

    // Field widths of the items.
    localparam int OP_W       = 3;
    localparam int TX_SLOT_W  = 4;
    localparam int PART_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int ERR_W      = 3;
    localparam int AGE_W      = 16;
    localparam int TIMEOUT_W  = 16;

    // Width used for range checks against the table geometry.
    localparam int WIDE_W = 10;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [AGE_W-1:0]     AGE_MAX       = '1;

    typedef logic [MAX_PARTICIPANTS-1:0] t_pmask;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN    = 3'd0,
        OP_REGISTER = 3'd1,
        OP_VOTE     = 3'd2,
        OP_QUERY    = 3'd3,
        OP_TICK     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        SLOT_UNUSED    = 2'd0,
        SLOT_PENDING   = 2'd1,
        SLOT_COMMITTED = 2'd2,
        SLOT_ROLLED    = 2'd3
    } t_slot_st;

    typedef enum logic [STATUS_W-1:0] {
        TX_PENDING   = 2'd0,
        TX_COMMITTED = 2'd1,
        TX_ROLLED    = 2'd2
    } t_tx_st;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 3'd0,
        ERR_UNKNOWN = 3'd1,
        ERR_DUP     = 3'd2,
        ERR_NOTREG  = 3'd3,
        ERR_FULL    = 3'd4
    } t_err;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              sweep;
        logic              exec;
        logic [SLOT_W-1:0] sweep_idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_tick;
    } t_dp_stat;

    // Reported status of a slot; an unused slot reads as pending.
    function automatic t_tx_st tx_status_of(input t_slot_st st);
        t_tx_st res;
        unique case (st)
            SLOT_UNUSED, SLOT_PENDING: res = TX_PENDING;
            SLOT_COMMITTED:            res = TX_COMMITTED;
            SLOT_ROLLED:               res = TX_ROLLED;
            default:                   res = TX_PENDING;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/tpcvt_if.sv =====
interface tpcvt_in_if;
    import tpcvt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [TX_SLOT_W-1:0] tx_slot;
    logic [PART_W-1:0]    participant;
    logic                 vote_commit;

    modport source (output valid, output operation, output tx_slot, output participant,
                    output vote_commit, input ready);
    modport sink   (input valid, input operation, input tx_slot, input participant,
                    input vote_commit, output ready);
endinterface

interface tpcvt_out_if;
    import tpcvt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TX_SLOT_W-1:0] slot_out;
    logic [STATUS_W-1:0]  tx_status;
    logic [ERR_W-1:0]     error_code;

    modport source (output valid, output slot_out, output tx_status, output error_code,
                    input ready);
    modport sink   (input valid, input slot_out, input tx_status, input error_code,
                    output ready);
endinterface

// ===== hw/rtl/tpcvt_datapath.sv =====
module tpcvt_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [tpcvt_pkg::TIMEOUT_W-1:0]   i_cfg_wr_data,
    input  logic [tpcvt_pkg::OP_W-1:0]        i_operation,
    input  logic [tpcvt_pkg::TX_SLOT_W-1:0]   i_tx_slot,
    input  logic [tpcvt_pkg::PART_W-1:0]      i_participant,
    input  logic                              i_vote_commit,
    input  tpcvt_pkg::t_dp_cmd                i_cmd,
    output tpcvt_pkg::t_dp_stat               o_stat,
    output logic [tpcvt_pkg::TX_SLOT_W-1:0]   o_slot_out,
    output logic [tpcvt_pkg::STATUS_W-1:0]    o_tx_status,
    output logic [tpcvt_pkg::ERR_W-1:0]       o_error_code
);
    import tpcvt_pkg::*;

    // Slot table. Only the status needs a reset; begin clears the rest of a slot.
    t_slot_st           r_status [NUM_SLOTS];
    t_pmask             r_pmask  [NUM_SLOTS];
    t_pmask             r_vmask  [NUM_SLOTS];
    logic [AGE_W-1:0]   r_age    [NUM_SLOTS];
    logic [NEXT_W-1:0]  r_next_slot;
    logic [TIMEOUT_W-1:0] r_timeout;

    // Captured item.
    logic [OP_W-1:0]      r_op;
    logic [TX_SLOT_W-1:0] r_slot;
    logic [PART_W-1:0]    r_part;
    logic                 r_yes;

    // Result register.
    logic [TX_SLOT_W-1:0] r_slot_out;
    t_tx_st               r_tx_status;
    t_err                 r_err;

    logic [WIDE_W-1:0]    addr_wide;
    logic                 slot_in_range;
    logic                 part_in_range;
    logic [SLOT_W-1:0]    addr_idx;
    logic [SLOT_W-1:0]    rd_idx;
    t_pmask               part_bit;
    t_slot_st             rd_st;
    t_pmask               rd_pm;
    t_pmask               rd_vm;
    logic [AGE_W-1:0]     rd_age;
    logic [AGE_W-1:0]     age_inc;
    t_pmask               vm_new;

    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_idx;
    t_slot_st             wr_st;
    t_pmask               wr_pm;
    t_pmask               wr_vm;
    logic [AGE_W-1:0]     wr_age;
    logic                 next_inc;
    logic [TX_SLOT_W-1:0] n_slot_out;
    t_tx_st               n_tx_status;
    t_err                 n_err;

    assign o_stat.in_is_tick = (i_operation == OP_TICK);

    // Address decode and the single read port of the table.
    always_comb begin
        addr_wide     = WIDE_W'(r_slot);
        slot_in_range = addr_wide < WIDE_W'(NUM_SLOTS);
        part_in_range = WIDE_W'(r_part) < WIDE_W'(MAX_PARTICIPANTS);
        addr_idx      = addr_wide[SLOT_W-1:0];
        part_bit      = t_pmask'(1) << r_part;
        rd_idx        = i_cmd.sweep ? i_cmd.sweep_idx : addr_idx;
        rd_st         = r_status[rd_idx];
        rd_pm         = r_pmask[rd_idx];
        rd_vm         = r_vmask[rd_idx];
        rd_age        = r_age[rd_idx];
        age_inc       = (rd_age == AGE_MAX) ? rd_age : rd_age + 1'b1;
        vm_new        = rd_vm | part_bit;
    end

    // Operation logic: one read-modify-write of a slot and the result.
    always_comb begin
        wr_en       = 1'b0;
        wr_idx      = rd_idx;
        wr_st       = rd_st;
        wr_pm       = rd_pm;
        wr_vm       = rd_vm;
        wr_age      = rd_age;
        next_inc    = 1'b0;
        n_slot_out  = '0;
        n_tx_status = TX_PENDING;
        n_err       = ERR_OK;

        if (i_cmd.sweep) begin
            // Timeout sweep: age a pending slot and roll it back when overdue with votes missing.
            if (rd_st == SLOT_PENDING) begin
                wr_en  = 1'b1;
                wr_age = age_inc;
                if (age_inc > r_timeout && rd_vm != rd_pm) begin
                    wr_st = SLOT_ROLLED;
                end
            end
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_BEGIN: begin
                    if (r_next_slot >= NEXT_W'(NUM_SLOTS)) begin
                        n_err = ERR_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_idx     = r_next_slot[SLOT_W-1:0];
                        wr_st      = SLOT_PENDING;
                        wr_pm      = '0;
                        wr_vm      = '0;
                        wr_age     = '0;
                        next_inc   = 1'b1;
                        n_slot_out = TX_SLOT_W'(r_next_slot);
                    end
                end
                OP_REGISTER, OP_VOTE, OP_QUERY: begin
                    n_slot_out = r_slot;
                    if (!slot_in_range || rd_st == SLOT_UNUSED) begin
                        n_err = ERR_UNKNOWN;
                    end else begin
                        n_tx_status = tx_status_of(rd_st);
                        priority if (r_op == OP_QUERY) begin
                            n_err = ERR_OK;
                        end else if (!part_in_range) begin
                            n_err = ERR_NOTREG;
                        end else if (r_op == OP_REGISTER) begin
                            if ((rd_pm & part_bit) != '0) begin
                                n_err = ERR_DUP;
                            end else begin
                                wr_en = 1'b1;
                                wr_pm = rd_pm | part_bit;
                            end
                        end else begin
                            // Vote: record it, then decide a pending slot.
                            if ((rd_pm & part_bit) == '0) begin
                                n_err = ERR_NOTREG;
                            end else begin
                                wr_en = 1'b1;
                                wr_vm = vm_new;
                                if (rd_st == SLOT_PENDING) begin
                                    if (!r_yes) begin
                                        wr_st = SLOT_ROLLED;
                                    end else if (vm_new == rd_pm) begin
                                        wr_st = SLOT_COMMITTED;
                                    end
                                end
                                n_tx_status = tx_status_of(wr_st);
                            end
                        end
                    end
                end
                default: begin
                    n_err = ERR_OK;
                end
            endcase
        end
    end

    // Control registers: table status, allocation counter and timeout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_status[k] <= SLOT_UNUSED;
            end
            r_next_slot <= '0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            if (wr_en) begin
                r_status[wr_idx] <= wr_st;
            end
            if (next_inc) begin
                r_next_slot <= r_next_slot + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers: slot contents, captured item and result.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pmask[wr_idx] <= wr_pm;
            r_vmask[wr_idx] <= wr_vm;
            r_age[wr_idx]   <= wr_age;
        end
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_slot <= i_tx_slot;
            r_part <= i_participant;
            r_yes  <= i_vote_commit;
        end
        if (i_cmd.exec) begin
            r_slot_out  <= n_slot_out;
            r_tx_status <= n_tx_status;
            r_err       <= n_err;
        end
    end

    assign o_slot_out   = r_slot_out;
    assign o_tx_status  = r_tx_status;
    assign o_error_code = r_err;

endmodule

// ===== hw/rtl/tpcvt_ctrl.sv =====
module tpcvt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  tpcvt_pkg::t_dp_stat  i_stat,
    output tpcvt_pkg::t_dp_cmd   o_cmd
);
    import tpcvt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC
    } t_state;

    t_state            r_state;
    logic              r_in_ready;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_idx;

    logic accept;
    logic out_free;

    // Handshake decode and datapath commands.
    always_comb begin
        accept          = i_in_valid && r_in_ready;
        out_free        = !r_out_valid || i_out_ready;
        o_cmd.capture   = accept;
        o_cmd.sweep     = (r_state == S_SWEEP);
        o_cmd.exec      = (r_state == S_EXEC) && out_free;
        o_cmd.sweep_idx = r_idx;
    end

    // State machine with registered ready and valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        r_idx      <= '0;
                        r_state    <= i_stat.in_is_tick ? S_SWEEP : S_EXEC;
                    end else begin
                        // Ready opens in the first idle cycle after reset.
                        r_in_ready <= 1'b1;
                    end
                end
                S_SWEEP: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/two_phase_commit_vote_table.sv =====
// Two-phase commit coordinator vote table.
// The input channel takes one item: an operation (begin, register, vote, query
// or tick) with a slot, a participant and a vote bit. Every item gives exactly one
// result item on the output channel: the slot, its status and an error code.
// For begin, register, vote and query, the accepted item is captured, then one
// read-modify-write of the slot table loads the result register once the output
// register is free; the input reopens in the same cycle as the result turns valid.
// A tick walks the table one slot per cycle, then loads its result the same way.
// The block takes no new item until the current one has loaded its result.
// The prepare timeout register (reset 100 ticks) is written through the write enable
// and data inputs; the user must write it only while the block is idle (not enforced).
// Reset empties the table: all slots unused, allocation restarts at slot 0.
// The input is not ready during reset and opens in the cycle after it is released.
// The result sits in an output register. While the receiver stalls, the block
// still accepts one more item and holds it until the output register is free.
module two_phase_commit_vote_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tpcvt_pkg::TIMEOUT_W-1:0] i_cfg_wr_data,
    tpcvt_in_if.sink                        i_in,
    tpcvt_out_if.source                     o_out
);
    import tpcvt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer for capture, timeout sweep and result hand-off.
    tpcvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Slot table, operation logic and result register.
    tpcvt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_in.operation),
        .i_tx_slot     (i_in.tx_slot),
        .i_participant (i_in.participant),
        .i_vote_commit (i_in.vote_commit),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_slot_out    (o_out.slot_out),
        .o_tx_status   (o_out.tx_status),
        .o_error_code  (o_out.error_code)
    );

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpcvt_pkg::*;

    // Operation codes past the tick that the block must answer with an empty result.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_TICK + 1);
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

    localparam int unsigned TX_SLOT_MAX   = (1 << TX_SLOT_W) - 1;
    localparam int unsigned PART_MAX      = (1 << PART_W) - 1;
    localparam logic [TIMEOUT_W-1:0] SHORT_TIMEOUT = 16'd2;
    localparam int unsigned HOLD_AT       = 200;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned TAIL_CYCLES   = 3 * (NUM_SLOTS + 2);
    localparam int unsigned CYCLE_LIMIT   = 400_000;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TX_SLOT_W-1:0] slot;
        logic [PART_W-1:0]    part;
        logic                 yes;
    } t_table_cmd;

    typedef struct packed {
        logic [TX_SLOT_W-1:0] slot;
        t_tx_st               status;
        t_err                 err;
    } t_table_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Signals driven by the testbench, all known from time zero.
    logic                   cfg_wr_en   = 1'b0;
    logic [TIMEOUT_W-1:0]   cfg_wr_data = '0;
    logic                   drv_valid   = 1'b0;
    logic [OP_W-1:0]        drv_op      = '0;
    logic [TX_SLOT_W-1:0]   drv_slot    = '0;
    logic [PART_W-1:0]      drv_part    = '0;
    logic                   drv_yes     = 1'b0;
    logic                   sink_ready  = 1'b0;

    tpcvt_in_if  in_bus ();
    tpcvt_out_if out_bus ();

    assign in_bus.valid       = drv_valid;
    assign in_bus.operation   = drv_op;
    assign in_bus.tx_slot     = drv_slot;
    assign in_bus.participant = drv_part;
    assign in_bus.vote_commit = drv_yes;
    assign out_bus.ready      = sink_ready;

    two_phase_commit_vote_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the vote table and its timeout.
    t_slot_st             slot_state [NUM_SLOTS];
    t_pmask               reg_mask   [NUM_SLOTS];
    t_pmask               yes_mask   [NUM_SLOTS];
    logic [AGE_W-1:0]     slot_ticks [NUM_SLOTS];
    logic [NEXT_W-1:0]    alloc_next;
    logic [TIMEOUT_W-1:0] prepare_limit;

    t_table_cmd    cmd_queue [$];
    t_table_result table_expect [$];

    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 87;
    int unsigned cmds_queued   = 0;
    int unsigned slots_begun   = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned settings_used = 1;
    int unsigned commits_made  = 0;
    int unsigned no_rollbacks  = 0;
    int unsigned expiries      = 0;
    int unsigned full_answers  = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;

    // Status code reported for a slot state; an unused slot reports pending.
    function automatic t_tx_st slot_report(input t_slot_st st);
        case (st)
            SLOT_COMMITTED: return TX_COMMITTED;
            SLOT_ROLLED:    return TX_ROLLED;
            default:        return TX_PENDING;
        endcase
    endfunction

    // Apply one accepted item to the shadow table and return the result it must give.
    function automatic t_table_result table_apply(input logic [OP_W-1:0] op,
                                                  input logic [TX_SLOT_W-1:0] slot,
                                                  input logic [PART_W-1:0] part,
                                                  input logic yes);
        t_table_result r;
        int            idx;
        t_pmask        bit_sel;
        r.slot   = '0;
        r.status = TX_PENDING;
        r.err    = ERR_OK;
        idx      = int'(slot);
        if (op == OP_BEGIN) begin
            if (alloc_next >= NUM_SLOTS) begin
                r.err = ERR_FULL;
                full_answers++;
            end else begin
                idx             = int'(alloc_next);
                r.slot          = alloc_next[TX_SLOT_W-1:0];
                alloc_next      = alloc_next + 1'b1;
                slot_state[idx] = SLOT_PENDING;
                reg_mask[idx]   = '0;
                yes_mask[idx]   = '0;
                slot_ticks[idx] = '0;
            end
        end else if (op == OP_TICK) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_state[i] == SLOT_PENDING) begin
                    if (slot_ticks[i] != AGE_MAX)
                        slot_ticks[i] = slot_ticks[i] + 1'b1;
                    if (slot_ticks[i] > prepare_limit && yes_mask[i] != reg_mask[i]) begin
                        slot_state[i] = SLOT_ROLLED;
                        expiries++;
                    end
                end
            end
        end else if (op > OP_TICK) begin
            // Spare codes leave the table alone and answer with zeros.
        end else if (idx >= NUM_SLOTS || slot_state[idx] == SLOT_UNUSED) begin
            r.slot = slot;
            r.err  = ERR_UNKNOWN;
        end else begin
            r.slot   = slot;
            r.status = slot_report(slot_state[idx]);
            if (op == OP_QUERY) begin
                r.err = ERR_OK;
            end else if (int'(part) >= MAX_PARTICIPANTS) begin
                r.err = ERR_NOTREG;
            end else begin
                bit_sel = t_pmask'(1) << part;
                if (op == OP_REGISTER) begin
                    if ((reg_mask[idx] & bit_sel) != '0)
                        r.err = ERR_DUP;
                    else
                        reg_mask[idx] = reg_mask[idx] | bit_sel;
                end else if ((reg_mask[idx] & bit_sel) == '0) begin
                    r.err = ERR_NOTREG;
                end else begin
                    // A vote is always recorded; only a pending slot changes state.
                    yes_mask[idx] = yes_mask[idx] | bit_sel;
                    if (slot_state[idx] == SLOT_PENDING) begin
                        if (!yes) begin
                            slot_state[idx] = SLOT_ROLLED;
                            no_rollbacks++;
                        end else if (yes_mask[idx] == reg_mask[idx]) begin
                            slot_state[idx] = SLOT_COMMITTED;
                            commits_made++;
                        end
                    end
                    r.status = slot_report(slot_state[idx]);
                end
            end
        end
        return r;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [TX_SLOT_W-1:0] slot,
                             input logic [PART_W-1:0] part, input logic yes);
        cmd_queue.push_back('{op: op, slot: slot, part: part, yes: yes});
        cmds_queued++;
        if (op == OP_BEGIN)
            slots_begun++;
    endtask

    // One loose item, mostly aimed at slots that have been opened.
    task automatic queue_random_cmd();
        int unsigned          roll;
        logic [OP_W-1:0]      op;
        logic [TX_SLOT_W-1:0] slot;
        logic [PART_W-1:0]    part;
        logic                 yes;
        roll = $urandom_range(0, 99);
        part = PART_W'($urandom_range(0, PART_MAX));
        yes  = 1'($urandom_range(0, 1));
        if (slots_begun == 0 || $urandom_range(0, 9) == 0)
            slot = TX_SLOT_W'($urandom_range(0, TX_SLOT_MAX));
        else if (slots_begun >= NUM_SLOTS)
            slot = TX_SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        else
            slot = TX_SLOT_W'($urandom_range(0, slots_begun - 1));
        if (roll < 30) begin
            op = OP_REGISTER;
        end else if (roll < 60) begin
            op  = OP_VOTE;
            yes = ($urandom_range(0, 99) < 80);
        end else if (roll < 72) begin
            op = OP_QUERY;
        end else if (roll < 86) begin
            op = OP_TICK;
        end else if (roll < 92) begin
            // Begins are kept for whole transactions until the table is full.
            op = (slots_begun >= NUM_SLOTS) ? OP_BEGIN : OP_QUERY;
        end else begin
            op   = OP_W'($urandom_range(OP_REGISTER, OP_SPARE_LAST));
            slot = TX_SLOT_W'($urandom_range(0, TX_SLOT_MAX));
        end
        queue_cmd(op, slot, part, yes);
    endtask

    // Begin a slot, register distinct participants, then vote: commit, a no, or one short.
    task automatic queue_transaction();
        int unsigned          order [MAX_PARTICIPANTS];
        int unsigned          n_part, outcome, no_at, k, tmp;
        logic [TX_SLOT_W-1:0] slot_id;
        slot_id = TX_SLOT_W'(slots_begun);
        queue_cmd(OP_BEGIN, TX_SLOT_W'($urandom_range(0, TX_SLOT_MAX)), '0, 1'b0);
        for (int j = 0; j < MAX_PARTICIPANTS; j++)
            order[j] = j;
        for (int j = MAX_PARTICIPANTS - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        n_part  = $urandom_range(1, MAX_PARTICIPANTS);
        outcome = $urandom_range(0, 9);
        no_at   = $urandom_range(0, n_part - 1);
        for (int j = 0; j < n_part; j++) begin
            queue_cmd(OP_REGISTER, slot_id, PART_W'(order[j]), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 20)
                queue_random_cmd();
        end
        for (int j = 0; j < n_part; j++) begin
            if (!(outcome >= 8 && j == n_part - 1)) begin
                queue_cmd(OP_VOTE, slot_id, PART_W'(order[j]),
                          !(outcome >= 6 && outcome < 8 && j == no_at));
                if ($urandom_range(0, 99) < 20)
                    queue_random_cmd();
            end
        end
        queue_cmd(OP_QUERY, slot_id, '0, 1'b0);
    endtask

    // Hold the stimulus until every queued item has been answered.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (cmd_queue.size() != 0 || drv_valid || table_expect.size() != 0);
    endtask

    task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        prepare_limit  = value;
        settings_used++;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned new_slots);
        int unsigned start, opened;
        start  = cmds_queued;
        opened = 0;
        while (cmds_queued - start < n_items) begin
            if (opened < new_slots && slots_begun < NUM_SLOTS && $urandom_range(0, 99) < 6) begin
                queue_transaction();
                opened++;
            end else begin
                queue_random_cmd();
            end
        end
        wait_drained();
    endtask

    // Driver: offer the next queued item once the current one has been taken.
    always @(posedge i_clk) begin : drive
        t_table_cmd cmd;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_bus.ready) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cmd        = cmd_queue.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= cmd.op;
                drv_slot  <= cmd.slot;
                drv_part  <= cmd.part;
                drv_yes   <= cmd.yes;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else if (hold_left != 0) begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            sink_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            sink_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check each result against the oldest prediction, then predict new items.
    always @(posedge i_clk) begin : monitor
        t_table_result want;
        if (i_rst_n) begin
            if (out_bus.valid && sink_ready) begin
                if (table_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: slot %0d status %0d error %0d",
                                 out_bus.slot_out, out_bus.tx_status, out_bus.error_code);
                end else begin
                    want = table_expect.pop_front();
                    if (out_bus.slot_out !== want.slot || out_bus.tx_status !== want.status ||
                        out_bus.error_code !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: slot %0d/%0d status %0d/%0d error %0d/%0d %s",
                                     results_seen, want.slot, out_bus.slot_out, want.status,
                                     out_bus.tx_status, want.err, out_bus.error_code,
                                     "(expected/actual)");
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (drv_valid && in_bus.ready)
                table_expect.push_back(table_apply(drv_op, drv_slot, drv_part, drv_yes));
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("timeout after %0d cycles", n_cycles);
        $display("two_phase_commit_vote_table test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned late_slot;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state[i] = SLOT_UNUSED;
            reg_mask[i]   = '0;
            yes_mask[i]   = '0;
            slot_ticks[i] = '0;
        end
        alloc_next    = '0;
        prepare_limit = TIMEOUT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: unknown slots, duplicates, unregistered votes, finished slots, spares.
        queue_cmd(OP_QUERY, 4'd5, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd15, 3'd7, 1'b1);
        queue_cmd(OP_VOTE, 4'd9, 3'd0, 1'b1);
        queue_cmd(OP_BEGIN, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd0, 3'd7, 1'b0);
        queue_cmd(OP_REGISTER, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_VOTE, 4'd0, 3'd3, 1'b1);
        queue_cmd(OP_VOTE, 4'd0, 3'd0, 1'b1);
        queue_cmd(OP_TICK, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_VOTE, 4'd0, 3'd7, 1'b1);
        queue_cmd(OP_VOTE, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd0, 3'd5, 1'b0);
        queue_cmd(OP_QUERY, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_BEGIN, 4'd15, 3'd7, 1'b1);
        queue_cmd(OP_REGISTER, 4'd1, 3'd6, 1'b1);
        queue_cmd(OP_VOTE, 4'd1, 3'd6, 1'b0);
        queue_cmd(OP_BEGIN, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd2, 3'd2, 1'b0);
        queue_cmd(OP_REGISTER, 4'd2, 3'd3, 1'b0);
        queue_cmd(OP_VOTE, 4'd2, 3'd2, 1'b1);
        queue_cmd(OP_BEGIN, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_SPARE_FIRST, 4'd15, 3'd7, 1'b1);
        queue_cmd(OP_SPARE_FIRST + 1'b1, 4'd15, 3'd7, 1'b1);
        queue_cmd(OP_SPARE_LAST, 4'd15, 3'd7, 1'b1);

        // Zero timeout: one tick expires a slot short of votes, not one with no participants.
        set_timeout('0);
        queue_cmd(OP_TICK, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_QUERY, 4'd2, 3'd0, 1'b0);
        queue_cmd(OP_QUERY, 4'd3, 3'd0, 1'b0);
        queue_cmd(OP_REGISTER, 4'd3, 3'd4, 1'b0);
        queue_cmd(OP_TICK, 4'd0, 3'd0, 1'b0);
        queue_cmd(OP_QUERY, 4'd3, 3'd0, 1'b0);

        // Random phases under the three idling patterns.
        set_timeout(16'd5);
        run_random_phase(600, 5);
        send_idle_pct = 87;
        recv_idle_pct = 8;
        set_timeout('1);
        run_random_phase(600, 4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timeout(TIMEOUT_W'($urandom_range(1, 30)));
        run_random_phase(600, 2);

        // A pending slot with a missing vote expires just past a short timeout.
        set_timeout(SHORT_TIMEOUT);
        late_slot = (slots_begun < NUM_SLOTS) ? slots_begun : 0;
        if (slots_begun < NUM_SLOTS)
            queue_cmd(OP_BEGIN, '0, '0, 1'b0);
        queue_cmd(OP_REGISTER, TX_SLOT_W'(late_slot), 3'd0, 1'b1);
        repeat (SHORT_TIMEOUT) queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_QUERY, TX_SLOT_W'(late_slot), '0, 1'b0);
        queue_cmd(OP_TICK, '0, '0, 1'b0);
        queue_cmd(OP_QUERY, TX_SLOT_W'(late_slot), '0, 1'b0);
        while (slots_begun < NUM_SLOTS + 2)
            queue_cmd(OP_BEGIN, TX_SLOT_W'($urandom_range(0, TX_SLOT_MAX)), '0, 1'b0);

        // A last mixed stretch on the full table.
        send_idle_pct = 8;
        recv_idle_pct = 87;
        run_random_phase(60, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("checked %0d results over %0d timeout settings, %0d slots opened",
                 results_seen, settings_used, alloc_next);
        $display("seen %0d commits, %0d no-vote rollbacks, %0d expiries, %0d table-full answers",
                 commits_made, no_rollbacks, expiries, full_answers);
        if (mismatches == 0 && table_expect.size() == 0) begin
            $display("two_phase_commit_vote_table test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, table_expect.size());
            $display("two_phase_commit_vote_table test failed");
        end
        $finish;
    end

endmodule

// ===== two_phase_commit_vote_table.f =====
hw/rtl/tpcvt_pkg.sv
hw/rtl/tpcvt_if.sv
hw/rtl/tpcvt_datapath.sv
hw/rtl/tpcvt_ctrl.sv
hw/rtl/two_phase_commit_vote_table.sv
dv/tb.sv
